// ===== design/zci_pkg.sv =====
// shared control and status types for the zero crossing interpolator
package zci_pkg;

   // command word from the sequencer to the serial multiply-divide unit
   typedef struct packed {
      logic start;
   } zci_ctl_type;

   // status word from the serial multiply-divide unit
   typedef struct packed {
      logic busy;
      logic done;
   } zci_sts_type;

endpackage

// ===== design/zci_req_if.sv =====
// sample channel interface: key, value and series marker with valid/ready
interface zci_req_if #(
   parameter int SAMPLE_WIDTH = 32
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_key;
   logic signed [SAMPLE_WIDTH-1:0] sample_value;
   logic                           series_start;

   modport source (
      output valid, sample_key, sample_value, series_start,
      input  ready
   );

   modport sink (
      input  valid, sample_key, sample_value, series_start,
      output ready
   );
endinterface

// ===== design/zci_rsp_if.sv =====
// crossing result channel interface with valid/ready
interface zci_rsp_if #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int INDEX_WIDTH  = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] crossing_key;
   logic signed [SAMPLE_WIDTH-1:0] crossing_value;
   logic [INDEX_WIDTH-1:0]         segment_index;
   logic                           degenerate_keys;

   modport source (
      output valid, crossing_key, crossing_value, segment_index, degenerate_keys,
      input  ready
   );

   modport sink (
      input  valid, crossing_key, crossing_value, segment_index, degenerate_keys,
      output ready
   );
endinterface

// ===== design/zero_crossing_interpolator.sv =====
// zero crossing detector with linear interpolation of key and value, top level
// sequence: a word without a crossing is absorbed while the sequencer stays idle; a degenerate
//   (equal keys) crossing goes from accept to the load state and then to the result register;
//   a true crossing is set by two passes of the bit-serial
//   multiply-divide unit (SAMPLE_WIDTH+1 multiply steps and 2*SAMPLE_WIDTH+2 divide steps)
// throughput: one sample word at a time; the next word is taken once the result is parked
// reset: synchronous, clears history, segment count, sequencer and result valid
module zero_crossing_interpolator #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int INDEX_WIDTH  = 16
) (
   input  logic      clock,
   input  logic      reset,
   zci_req_if.sink   req,
   zci_rsp_if.source rsp
);
   import zci_pkg::*;

   localparam int W  = SAMPLE_WIDTH;
   localparam int OP = SAMPLE_WIDTH + 1;   // magnitudes of differences
   localparam int EW = SAMPLE_WIDTH + 2;   // signed sums before clamping

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_WAIT1 = 3'd2;
   localparam logic [2:0] ST_WAIT2 = 3'd3;
   localparam logic [2:0] ST_SUM   = 3'd4;
   localparam logic [2:0] ST_SATV  = 3'd5;
   localparam logic [2:0] ST_LOAD  = 3'd6;

   localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = {INDEX_WIDTH{1'b1}};

   // clamp a widened signed sum into the sample range
   function automatic logic signed [W-1:0] clamp(input logic signed [EW-1:0] v);
      logic [EW-W:0] top;
      begin
         top = v[EW-1:W-1];
         if ((&top) || !(|top)) begin
            clamp = v[W-1:0];
         end else if (v[EW-1]) begin
            clamp = {1'b1, {(W-1){1'b0}}};
         end else begin
            clamp = {1'b0, {(W-1){1'b1}}};
         end
      end
   endfunction

   // sequencer and history
   logic [2:0]             state_ff, state_in;
   logic signed [W-1:0]    prev_key_ff, prev_key_in;
   logic signed [W-1:0]    prev_value_ff, prev_value_in;
   logic                   have_prev_ff, have_prev_in;
   logic [INDEX_WIDTH-1:0] seg_count_ff, seg_count_in;

   // working registers of one crossing
   logic signed [W-1:0]    x1_ff, x1_in;
   logic signed [W-1:0]    y1_ff, y1_in;
   logic signed [OP-1:0]   dx_ff, dx_in;
   logic signed [OP-1:0]   dy_ff, dy_in;
   logic [OP-1:0]          a_ff, a_in;
   logic [OP-1:0]          b_ff, b_in;
   logic [OP-1:0]          d_ff, d_in;
   logic                   start_ff, start_in;
   logic signed [EW-1:0]   u_ff, u_in;
   logic signed [EW-1:0]   rs_ff, rs_in;
   logic signed [EW-1:0]   xs_ff, xs_in;
   logic signed [EW-1:0]   ys_ff, ys_in;
   logic signed [W-1:0]    key_ff, key_in;
   logic signed [W-1:0]    val_ff, val_in;
   logic [INDEX_WIDTH-1:0] index_ff, index_in;
   logic                   degen_ff, degen_in;

   // result register, parts the sequencer from the result channel
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]    out_key_ff, out_key_in;
   logic signed [W-1:0]    out_value_ff, out_value_in;
   logic [INDEX_WIDTH-1:0] out_index_ff, out_index_in;
   logic                   out_degen_ff, out_degen_in;

   zci_ctl_type            mdv_ctl;
   zci_sts_type            mdv_sts;
   logic [OP-1:0]          mdv_quo;

   logic                   req_take;
   logic                   rsp_take;
   logic                   load_ok;
   logic                   y1_neg, y1_pos, y2_neg, y2_pos;
   logic                   crossing;
   logic [OP-1:0]          mag_y1, mag_dx, mag_dy;
   logic [EW-1:0]          quo_wide;

   zci_muldiv #(
      .OP_WIDTH (OP)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mdv_ctl),
      .op_a     (a_ff),
      .op_b     (b_ff),
      .op_d     (d_ff),
      .sts      (mdv_sts),
      .quotient (mdv_quo)
   );

   assign mdv_ctl.start = start_ff;

   // sample words are taken only while the sequencer rests
   assign req.ready = (state_ff == ST_IDLE) && !mdv_sts.busy;
   assign req_take  = req.valid && req.ready;
   assign rsp_take  = rsp_valid_ff && rsp.ready;
   assign load_ok   = !rsp_valid_ff || rsp.ready;

   // strict sign test, zero values never cross
   assign y1_neg   = prev_value_ff[W-1];
   assign y1_pos   = !prev_value_ff[W-1] && (|prev_value_ff);
   assign y2_neg   = req.sample_value[W-1];
   assign y2_pos   = !req.sample_value[W-1] && (|req.sample_value);
   assign crossing = (y1_neg && y2_pos) || (y1_pos && y2_neg);

   // magnitudes feeding the first pass
   assign mag_y1 = y1_ff[W-1] ? (~{y1_ff[W-1], y1_ff} + 1'b1) : {y1_ff[W-1], y1_ff};
   assign mag_dx = dx_ff[OP-1] ? (~dx_ff + 1'b1) : dx_ff;
   assign mag_dy = dy_ff[OP-1] ? (~dy_ff + 1'b1) : dy_ff;

   assign quo_wide = {1'b0, mdv_quo};

   always_comb begin
      state_in      = state_ff;
      prev_key_in   = prev_key_ff;
      prev_value_in = prev_value_ff;
      have_prev_in  = have_prev_ff;
      seg_count_in  = seg_count_ff;
      x1_in         = x1_ff;
      y1_in         = y1_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      d_in          = d_ff;
      start_in      = 1'b0;
      u_in          = u_ff;
      rs_in         = rs_ff;
      xs_in         = xs_ff;
      ys_in         = ys_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      index_in      = index_ff;
      degen_in      = degen_ff;
      rsp_valid_in  = rsp_take ? 1'b0 : rsp_valid_ff;
      out_key_in    = out_key_ff;
      out_value_in  = out_value_ff;
      out_index_in  = out_index_ff;
      out_degen_in  = out_degen_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               prev_key_in   = req.sample_key;
               prev_value_in = req.sample_value;
               have_prev_in  = 1'b1;
               if (req.series_start || !have_prev_ff) begin
                  // new series: history replaced, index restarts
                  seg_count_in = '0;
               end else begin
                  if (seg_count_ff != INDEX_MAX) begin
                     seg_count_in = seg_count_ff + 1'b1;
                  end
                  if (crossing) begin
                     x1_in    = prev_key_ff;
                     y1_in    = prev_value_ff;
                     dx_in    = {req.sample_key[W-1], req.sample_key}
                              - {prev_key_ff[W-1], prev_key_ff};
                     dy_in    = {req.sample_value[W-1], req.sample_value}
                              - {prev_value_ff[W-1], prev_value_ff};
                     index_in = seg_count_ff;
                     if (req.sample_key == prev_key_ff) begin
                        // equal keys: crossing at the common key, value zero
                        key_in   = prev_key_ff;
                        val_in   = '0;
                        degen_in = 1'b1;
                        state_in = ST_LOAD;
                     end else begin
                        degen_in = 1'b0;
                        state_in = ST_PREP;
                     end
                  end
               end
            end
         end
         ST_PREP: begin
            // first pass: |y1| * |dx| / |dy|
            a_in     = mag_y1;
            b_in     = mag_dx;
            d_in     = mag_dy;
            start_in = 1'b1;
            state_in = ST_WAIT1;
         end
         ST_WAIT1: begin
            if (mdv_sts.done) begin
               // second pass: |u| * |dy| / |dx|, operands swapped in place
               a_in     = mdv_quo;
               b_in     = d_ff;
               d_in     = b_ff;
               start_in = 1'b1;
               u_in     = dx_ff[OP-1] ? (~quo_wide + 1'b1) : quo_wide;
               state_in = ST_WAIT2;
            end
         end
         ST_WAIT2: begin
            if (mdv_sts.done) begin
               rs_in    = dy_ff[OP-1] ? (~quo_wide + 1'b1) : quo_wide;
               xs_in    = {{(EW-W){x1_ff[W-1]}}, x1_ff} + u_ff;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            ys_in    = {{(EW-W){y1_ff[W-1]}}, y1_ff} + rs_ff;
            key_in   = clamp(xs_ff);
            state_in = ST_SATV;
         end
         ST_SATV: begin
            val_in   = clamp(ys_ff);
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // park the word once the result register is free
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               out_key_in   = key_ff;
               out_value_in = val_ff;
               out_index_in = index_ff;
               out_degen_in = degen_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_key_ff   <= '0;
         prev_value_ff <= '0;
         have_prev_ff  <= 1'b0;
         seg_count_ff  <= '0;
         start_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_key_ff   <= prev_key_in;
         prev_value_ff <= prev_value_in;
         have_prev_ff  <= have_prev_in;
         seg_count_ff  <= seg_count_in;
         start_ff      <= start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      d_ff         <= d_in;
      u_ff         <= u_in;
      rs_ff        <= rs_in;
      xs_ff        <= xs_in;
      ys_ff        <= ys_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      index_ff     <= index_in;
      degen_ff     <= degen_in;
      out_key_ff   <= out_key_in;
      out_value_ff <= out_value_in;
      out_index_ff <= out_index_in;
      out_degen_ff <= out_degen_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.crossing_key    = out_key_ff;
   assign rsp.crossing_value  = out_value_ff;
   assign rsp.segment_index   = out_index_ff;
   assign rsp.degenerate_keys = out_degen_ff;

endmodule

// ===== design/zci_muldiv.sv =====
// bit-serial unit computing floor(a * b / d) by shift-add multiply then restoring divide
module zci_muldiv #(
   parameter int OP_WIDTH = 33
) (
   input  logic                  clock,
   input  logic                  reset,
   input  zci_pkg::zci_ctl_type  ctl,
   input  logic [OP_WIDTH-1:0]   op_a,
   input  logic [OP_WIDTH-1:0]   op_b,
   input  logic [OP_WIDTH-1:0]   op_d,
   output zci_pkg::zci_sts_type  sts,
   output logic [OP_WIDTH-1:0]   quotient
);
   import zci_pkg::*;

   localparam int CNT_WIDTH = $clog2(2 * OP_WIDTH);
   localparam logic [CNT_WIDTH-1:0] MUL_LAST = CNT_WIDTH'(OP_WIDTH - 1);
   localparam logic [CNT_WIDTH-1:0] DIV_LAST = CNT_WIDTH'(2 * OP_WIDTH - 1);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;

   logic [1:0]           phase_ff, phase_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [OP_WIDTH-1:0]  hi_ff, hi_in;
   logic [OP_WIDTH-1:0]  lo_ff, lo_in;
   logic [OP_WIDTH-1:0]  mcand_ff, mcand_in;
   logic [OP_WIDTH-1:0]  dvsr_ff, dvsr_in;
   logic [OP_WIDTH-1:0]  rem_ff, rem_in;
   logic [OP_WIDTH-1:0]  quo_ff, quo_in;

   logic [OP_WIDTH:0]    add_sum;
   logic [OP_WIDTH:0]    trial;
   logic [OP_WIDTH:0]    trial_diff;
   logic                 trial_ge;

   // one partial product per cycle
   assign add_sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : {(OP_WIDTH+1){1'b0}});

   // one quotient bit per cycle, numerator bits taken msb first from the product
   assign trial      = {rem_ff, hi_ff[OP_WIDTH-1]};
   assign trial_ge   = trial >= {1'b0, dvsr_ff};
   assign trial_diff = trial - {1'b0, dvsr_ff};

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      dvsr_in  = dvsr_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (ctl.start) begin
               hi_in    = '0;
               lo_in    = op_b;
               mcand_in = op_a;
               dvsr_in  = op_d;
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            hi_in  = add_sum[OP_WIDTH:1];
            lo_in  = {add_sum[0], lo_ff[OP_WIDTH-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            hi_in  = {hi_ff[OP_WIDTH-2:0], lo_ff[OP_WIDTH-1]};
            lo_in  = {lo_ff[OP_WIDTH-2:0], 1'b0};
            rem_in = trial_ge ? trial_diff[OP_WIDTH-1:0] : trial[OP_WIDTH-1:0];
            quo_in = {quo_ff[OP_WIDTH-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
      dvsr_ff  <= dvsr_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   assign sts.busy = (phase_ff != PH_IDLE);
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule
